>>> hw/rtl/plr_pkg.sv
// ----------------------------------------------------------------------------
// plr_pkg: shared types and constants of the parametric line rasteriser
// Coordinate width, derived datapath widths, opcodes, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package plr_pkg;

  // Width of one screen coordinate.
  localparam int unsigned COORD_BITS = 12;
  // Width of twice an absolute delta, and of the sum of both deltas.
  localparam int unsigned DELTA2_BITS = COORD_BITS + 1;
  localparam int unsigned SUM_BITS = COORD_BITS + 1;
  // Width of twice the delta sum, and of the point count (up to w + 1).
  localparam int unsigned SUM2_BITS = COORD_BITS + 2;
  localparam int unsigned COUNT_BITS = COORD_BITS + 2;
  // Accumulators and thresholds grow to about 2a times (w + 1).
  localparam int unsigned ACC_BITS = 2 * COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DELTA2_BITS-1:0] delta2_t;
  typedef logic [SUM_BITS-1:0] sum_t;
  typedef logic [SUM2_BITS-1:0] sum2_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ACC_BITS-1:0] acc_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_ACTIVE = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } status_t;

endpackage

>>> hw/rtl/plr_if.sv
// ----------------------------------------------------------------------------
// plr_if: handshake channels of the line rasteriser
// One interface for command words and one for point words, each with a
// source and a sink modport.
// ----------------------------------------------------------------------------
interface plr_in_if;
  logic              valid;
  logic              ready;
  plr_pkg::opcode_e  opcode;
  plr_pkg::coord_t   start_x;
  plr_pkg::coord_t   start_y;
  plr_pkg::coord_t   end_x;
  plr_pkg::coord_t   end_y;

  modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface plr_out_if;
  logic            valid;
  logic            ready;
  plr_pkg::coord_t point_x;
  plr_pkg::coord_t point_y;
  logic            last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

>>> hw/rtl/plr_ctrl.sv
// ----------------------------------------------------------------------------
// plr_ctrl: controller of the line rasteriser
// Tracks whether a line is active, issues load and step commands to the
// datapath and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module plr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  plr_pkg::opcode_e  opcode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  plr_pkg::status_t  status_i,
  output plr_pkg::cmd_t     cmd_o
);
  import plr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;

  // A word is taken whenever the output register is free or being emptied.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_accept) begin
      unique case (opcode_i)
        OP_START: begin
          cmd_o.load = 1'b1;
          state_d    = ST_ACTIVE;
        end
        OP_STEP: begin
          if (state_q == ST_ACTIVE) begin
            cmd_o.step  = 1'b1;
            out_valid_d = 1'b1;
            if (status_i.last) begin
              state_d = ST_IDLE;
            end
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_step_only_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> state_q == ST_ACTIVE)
    else $error("step issued with no active line");
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && status_i.last) |=> state_q == ST_IDLE)
    else $error("controller still active after the last point");
  a_step_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |=> out_valid_q)
    else $error("step did not fill the output register");
  a_load_step_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.step))
    else $error("load and step issued together");
`endif

endmodule

>>> hw/rtl/plr_datapath.sv
// ----------------------------------------------------------------------------
// plr_datapath: arithmetic of the line rasteriser
// Holds the current point, deltas, thresholds, accumulators and point count,
// and the payload of the output register.
// ----------------------------------------------------------------------------
module plr_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plr_pkg::cmd_t     cmd_i,
  output plr_pkg::status_t  status_o,
  input  plr_pkg::coord_t   start_x_i,
  input  plr_pkg::coord_t   start_y_i,
  input  plr_pkg::coord_t   end_x_i,
  input  plr_pkg::coord_t   end_y_i,
  output plr_pkg::coord_t   point_x_o,
  output plr_pkg::coord_t   point_y_o,
  output logic              last_point_o
);
  import plr_pkg::*;

  coord_t  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic    neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  delta2_t dx2_q, dx2_d, dy2_q, dy2_d;
  sum2_t   sum2_q, sum2_d;
  acc_t    thr_x_q, thr_x_d, thr_y_q, thr_y_d;
  acc_t    acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  count_t  left_q, left_d;
  coord_t  pt_x_q, pt_y_q;
  logic    pt_last_q;

  coord_t  delta_x, delta_y;
  logic    sx_neg, sy_neg;
  sum_t    w;
  logic    move_x, move_y;
  coord_t  step_x, step_y;

  assign status_o.last = (left_q <= count_t'(1));

  // Absolute deltas and their sum for a new line.
  always_comb begin
    sx_neg  = end_x_i < start_x_i;
    sy_neg  = end_y_i < start_y_i;
    delta_x = sx_neg ? start_x_i - end_x_i : end_x_i - start_x_i;
    delta_y = sy_neg ? start_y_i - end_y_i : end_y_i - start_y_i;
    w       = {1'b0, delta_x} + {1'b0, delta_y};
  end

  // Next point: move along each axis whose accumulator passed its threshold.
  always_comb begin
    move_x = thr_x_q < acc_x_q;
    move_y = thr_y_q < acc_y_q;
    step_x = neg_x_q ? cur_x_q - coord_t'(1) : cur_x_q + coord_t'(1);
    step_y = neg_y_q ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1);
  end

  // Next values of the line state.
  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    neg_x_d = neg_x_q;
    neg_y_d = neg_y_q;
    dx2_d   = dx2_q;
    dy2_d   = dy2_q;
    sum2_d  = sum2_q;
    thr_x_d = thr_x_q;
    thr_y_d = thr_y_q;
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    left_d  = left_q;
    if (cmd_i.load) begin
      cur_x_d = start_x_i;
      cur_y_d = start_y_i;
      neg_x_d = sx_neg;
      neg_y_d = sy_neg;
      dx2_d   = {delta_x, 1'b0};
      dy2_d   = {delta_y, 1'b0};
      sum2_d  = {w, 1'b0};
      thr_x_d = acc_t'(w);
      thr_y_d = acc_t'(w);
      acc_x_d = '0;
      acc_y_d = '0;
      left_d  = count_t'(w) + count_t'(1);
    end else if (cmd_i.step) begin
      if (move_x) begin
        cur_x_d = step_x;
        thr_x_d = thr_x_q + acc_t'(sum2_q);
      end
      if (move_y) begin
        cur_y_d = step_y;
        thr_y_d = thr_y_q + acc_t'(sum2_q);
      end
      acc_x_d = acc_x_q + acc_t'(dx2_q);
      acc_y_d = acc_y_q + acc_t'(dy2_q);
      left_d  = status_o.last ? '0 : left_q - count_t'(1);
    end
  end

  // Line state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      neg_x_q <= 1'b0;
      neg_y_q <= 1'b0;
      dx2_q   <= '0;
      dy2_q   <= '0;
      sum2_q  <= '0;
      thr_x_q <= '0;
      thr_y_q <= '0;
      acc_x_q <= '0;
      acc_y_q <= '0;
      left_q  <= '0;
    end else begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      neg_x_q <= neg_x_d;
      neg_y_q <= neg_y_d;
      dx2_q   <= dx2_d;
      dy2_q   <= dy2_d;
      sum2_q  <= sum2_d;
      thr_x_q <= thr_x_d;
      thr_y_q <= thr_y_d;
      acc_x_q <= acc_x_d;
      acc_y_q <= acc_y_d;
      left_q  <= left_d;
    end
  end

  // Output register payload, loaded with each emitted point.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      pt_x_q    <= cur_x_d;
      pt_y_q    <= cur_y_d;
      pt_last_q <= status_o.last;
    end
  end

  assign point_x_o    = pt_x_q;
  assign point_y_o    = pt_y_q;
  assign last_point_o = pt_last_q;

endmodule

>>> hw/rtl/parametric_line_rasterizer.sv
// ----------------------------------------------------------------------------
// parametric_line_rasterizer: top level of the parametric line rasteriser
// A start word loads a new line and yields no point; a step word during an
// active line registers its point in the output register as it is accepted.
// Throughput is one word per cycle while the output is drained; the single
// output register stalls the input when a point waits and is not taken.
// Asynchronous active-low reset returns the block to idle with no line
// loaded and the output register empty.
// ----------------------------------------------------------------------------
module parametric_line_rasterizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  plr_in_if.sink    in_i,
  plr_out_if.source out_o
);
  import plr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller: line state and handshakes.
  plr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .opcode_i    (in_i.opcode),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: deltas, accumulators and the emitted point.
  plr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .start_x_i    (in_i.start_x),
    .start_y_i    (in_i.start_y),
    .end_x_i      (in_i.end_x),
    .end_y_i      (in_i.end_y),
    .point_x_o    (out_o.point_x),
    .point_y_o    (out_o.point_y),
    .last_point_o (out_o.last_point)
  );

endmodule

>>> bench/tb_parametric_line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_parametric_line_rasterizer: self-checking bench for the line rasteriser
// Command words (start and step) go in over the input channel with random
// gaps, while the point channel is drained with random stalls. A tracker
// follows the rasteriser state on every accepted command word, queues the
// point each step should give, and compares every point word taken from the
// block against the oldest queued point.
// ----------------------------------------------------------------------------
module tb_parametric_line_rasterizer;
  import plr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned RANDOM_WORDS = 1750;
  localparam int unsigned COORD_MAX = (1 << COORD_BITS) - 1;
  // Step words spent on the stretch of the longest line at the end.
  localparam int unsigned LONG_STEPS = 200;

  // One command word as it crosses the input channel.
  typedef struct packed {
    opcode_e opcode;
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
  } command_t;

  // One point word as it crosses the output channel.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } point_t;

  // Follows the rasteriser state and holds the points still owed by the block.
  class point_tracker;
    coord_t   cur_x, cur_y;
    bit       x_down, y_down;
    delta2_t  dbl_dx, dbl_dy;
    sum2_t    dbl_sum;
    acc_t     thr_x, thr_y;
    acc_t     acc_x, acc_y;
    count_t   left;
    bit       drawing;
    point_t   pending_points[$];
    int       errors;

    function new();
      cur_x = '0;
      cur_y = '0;
      x_down = 1'b0;
      y_down = 1'b0;
      dbl_dx = '0;
      dbl_dy = '0;
      dbl_sum = '0;
      thr_x = '0;
      thr_y = '0;
      acc_x = '0;
      acc_y = '0;
      left = '0;
      drawing = 1'b0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Advances the state for one accepted command word.
    function void note_command(input command_t c);
      coord_t dx, dy;
      sum_t   w;
      point_t p;
      if (c.opcode == OP_START) begin
        x_down = c.end_x < c.start_x;
        y_down = c.end_y < c.start_y;
        dx = x_down ? c.start_x - c.end_x : c.end_x - c.start_x;
        dy = y_down ? c.start_y - c.end_y : c.end_y - c.start_y;
        w = sum_t'(dx) + sum_t'(dy);
        dbl_dx = {dx, 1'b0};
        dbl_dy = {dy, 1'b0};
        dbl_sum = {w, 1'b0};
        cur_x = c.start_x;
        cur_y = c.start_y;
        acc_x = '0;
        acc_y = '0;
        thr_x = acc_t'(w);
        thr_y = acc_t'(w);
        left = count_t'(w) + 1'b1;
        drawing = 1'b1;
      end else if (drawing) begin
        if (thr_x < acc_x) begin
          cur_x = x_down ? cur_x - 1'b1 : cur_x + 1'b1;
          thr_x = thr_x + acc_t'(dbl_sum);
        end
        if (thr_y < acc_y) begin
          cur_y = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
          thr_y = thr_y + acc_t'(dbl_sum);
        end
        acc_x = acc_x + acc_t'(dbl_dx);
        acc_y = acc_y + acc_t'(dbl_dy);
        p.x = cur_x;
        p.y = cur_y;
        p.last = left <= 1;
        if (left <= 1) begin
          left = '0;
          drawing = 1'b0;
        end else begin
          left = left - 1'b1;
        end
        pending_points.push_back(p);
      end
    endfunction

    // Compares one point word from the block with the oldest owed point.
    task check_point(input point_t got);
      point_t want;
      if (pending_points.size() == 0) begin
        report($sformatf("unexpected point x=%0d y=%0d last=%0b", got.x, got.y, got.last));
      end else begin
        want = pending_points.pop_front();
        if (got.x !== want.x)
          report($sformatf("point_x %0d, wanted %0d", got.x, want.x));
        if (got.y !== want.y)
          report($sformatf("point_y %0d, wanted %0d", got.y, want.y));
        if (got.last !== want.last)
          report($sformatf("last_point %0b, wanted %0b", got.last, want.last));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  plr_in_if  in_bus ();
  plr_out_if out_bus ();

  parametric_line_rasterizer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  point_tracker tracker = new();
  int unsigned  cycles;
  int unsigned  words_sent;
  bit           sender_calm;
  bit           sink_calm;

  // Clock with a 4 ns period.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Picks an endpoint within span of the given one, never wrapping round.
  function automatic coord_t near(input coord_t s, input int span);
    int d;
    d = $urandom_range(0, span);
    if ($urandom_range(0, 1) && int'(s) + d <= COORD_MAX) return coord_t'(int'(s) + d);
    if (int'(s) >= d) return coord_t'(int'(s) - d);
    return coord_t'(int'(s) + d);
  endfunction

  // Offers one word after an optional gap and holds it until it is taken.
  task send_word(input command_t c);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.opcode  <= c.opcode;
    in_bus.start_x <= c.start_x;
    in_bus.start_y <= c.start_y;
    in_bus.end_x   <= c.end_x;
    in_bus.end_y   <= c.end_y;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // Step word; its coordinate fields carry random junk.
  task send_step();
    command_t c;
    c.opcode  = OP_STEP;
    c.start_x = coord_t'($urandom);
    c.start_y = coord_t'($urandom);
    c.end_x   = coord_t'($urandom);
    c.end_y   = coord_t'($urandom);
    send_word(c);
  endtask

  // Start word followed by a number of step words.
  task draw_line(input coord_t sx, input coord_t sy, input coord_t ex, input coord_t ey,
                 input int steps);
    command_t c;
    c.opcode  = OP_START;
    c.start_x = sx;
    c.start_y = sy;
    c.end_x   = ex;
    c.end_y   = ey;
    send_word(c);
    repeat (steps) send_step();
  endtask

  // Holds the input off until every owed point has come out.
  task wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_points.size() != 0) @(posedge clk_i);
  endtask

  // Length of a line in points.
  function automatic int line_points(input coord_t sx, input coord_t sy, input coord_t ex,
                                     input coord_t ey);
    int a, b;
    a = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
    b = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
    return a + b + 1;
  endfunction

  // Point channel: ready with random stalls, with calm stretches in between.
  initial begin
    int stall_left;
    int stretch;
    stall_left = 0;
    stretch = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stretch == 0) begin
        sink_calm = $urandom_range(0, 4) == 0;
        stretch = $urandom_range(50, 400);
      end else begin
        stretch--;
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (!sink_calm && $urandom_range(0, 99) < 30) begin
        out_bus.ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Every accepted command word moves the tracker on.
  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready)
      tracker.note_command({in_bus.opcode, in_bus.start_x, in_bus.start_y,
                            in_bus.end_x, in_bus.end_y});
  end

  // Every accepted point word is checked.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      tracker.check_point({out_bus.point_x, out_bus.point_y, out_bus.last_point});
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus: directed words, random lines, then a stretch of the longest line.
  initial begin
    int     r;
    int     pts;
    int     steps;
    bit     mid_drained;
    coord_t sx, sy, ex, ey;
    cycles = 0;
    words_sent = 0;
    mid_drained = 1'b0;
    sender_calm = 1'b1;
    sink_calm = 1'b1;
    rst_ni <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.opcode  <= OP_STEP;
    in_bus.start_x <= '0;
    in_bus.start_y <= '0;
    in_bus.end_x   <= '0;
    in_bus.end_y   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: step with no line, equal endpoints at both corners, extreme
    // lines abandoned by a new start, and one short full line.
    sender_calm = 1'b0;
    send_word({OP_STEP, coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
               coord_t'(COORD_MAX)});
    draw_line('0, '0, '0, '0, 2);
    draw_line(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
              coord_t'(COORD_MAX), 1);
    draw_line('0, '0, coord_t'(COORD_MAX), coord_t'(COORD_MAX), 3);
    draw_line(coord_t'(COORD_MAX), coord_t'(COORD_MAX), '0, '0, 3);
    draw_line('0, coord_t'(COORD_MAX), coord_t'(COORD_MAX), '0, 2);
    draw_line(coord_t'(5), coord_t'(3), coord_t'(2), coord_t'(7), 9);
    wait_drained();

    // Random: mostly complete short lines, some cut short or over-stepped,
    // with lone steps and wide abandoned lines as noise.
    while (words_sent < RANDOM_WORDS - LONG_STEPS - 30) begin
      sender_calm = $urandom_range(0, 4) == 0;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        r = $urandom_range(0, 99);
        steps = (r < 70) ? 12 : (r < 95) ? 64 : 400;
        ex = near(sx, steps);
        ey = near(sy, steps);
        pts = line_points(sx, sy, ex, ey);
        r = $urandom_range(0, 9);
        if (r == 0) steps = $urandom_range(0, pts - 1);
        else if (r == 1) steps = pts + $urandom_range(1, 3);
        else steps = pts;
        draw_line(sx, sy, ex, ey, steps);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) send_step();
      end else begin
        draw_line(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), $urandom_range(1, 6));
      end
      if (!mid_drained && words_sent > RANDOM_WORDS / 2) begin
        wait_drained();
        mid_drained = 1'b1;
      end
    end

    // A stretch of the longest line runs the widest deltas through the
    // accumulators.
    sender_calm = 1'b0;
    draw_line('0, coord_t'(COORD_MAX), coord_t'(COORD_MAX), '0, LONG_STEPS);

    in_bus.valid <= 1'b0;
    while (tracker.pending_points.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending_points.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
